// ===== rtl/per_thread_load_tracker_macros.svh =====
// Assertion macros used by the checker of the load tracker.
`ifndef PER_THREAD_LOAD_TRACKER_MACROS_SVH
`define PER_THREAD_LOAD_TRACKER_MACROS_SVH

// Same-cycle implication, reset disables the check.
`define PTLT_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("load tracker check failed");

// Next-cycle implication, reset disables the check.
`define PTLT_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("load tracker check failed");

`endif

// ===== rtl/ptlt_pkg.sv =====
package ptlt_pkg;

   localparam logic [1:0] OP_ROUND_START = 2'd0;
   localparam logic [1:0] OP_SAMPLE      = 2'd1;
   localparam logic [1:0] OP_ROUND_END   = 2'd2;
   localparam logic [1:0] OP_IGNORED     = 2'd3;

   localparam int QUEUE_DEPTH = 2;
   localparam logic [7:0] RATIO_MAX = 8'd255;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] thread_id;
      logic [63:0] core_busy_count;
      logic [63:0] core_all_count;
      logic        stats_ok;
      logic [63:0] thread_cycles;
      logic [31:0] stk_bytes;
      logic [31:0] stk_free;
      logic        stack_ok;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] core_load;
      logic [7:0] cpu_share;
      logic [7:0] stk_share;
      logic [7:0] seen_threads;
      logic [7:0] round_counter;
      logic       no_slot;
      logic       over_limit;
   } rsp_type;

   // Classified request handed from the front to the back.
   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] tid;
      logic [63:0] busy;
      logic [63:0] all;
      logic        ok;
      logic [63:0] tcycles;
      logic [31:0] used;
      logic [31:0] size;
   } cmd_type;

   typedef struct packed {
      logic        start;
      logic [31:0] num;
      logic [31:0] den;
   } ratio_req_type;

   typedef struct packed {
      logic       done;
      logic [7:0] q;
   } ratio_rsp_type;

endpackage

// ===== rtl/ptlt_front.sv =====
module ptlt_front (
   input  logic              req_valid,
   output logic              req_ready,
   input  ptlt_pkg::req_type req_data,
   output logic              push_valid,
   input  logic              push_ready,
   output ptlt_pkg::cmd_type push_data
);

   logic [31:0] unused;

   // Accept whenever the queue has room; drop the unused opcode.
   assign req_ready  = push_ready;
   assign push_valid = req_valid && (req_data.operation != ptlt_pkg::OP_IGNORED);

   always_comb begin
      unused = req_data.stack_ok ? req_data.stk_free : 32'd0;
      push_data.op      = req_data.operation;
      push_data.tid     = req_data.thread_id;
      push_data.busy    = req_data.core_busy_count;
      push_data.all     = req_data.core_all_count;
      push_data.ok      = req_data.stats_ok;
      push_data.tcycles = req_data.thread_cycles;
      push_data.size    = req_data.stk_bytes;
      push_data.used    = (unused > req_data.stk_bytes) ? 32'd0
                                                        : req_data.stk_bytes - unused;
   end

endmodule

// ===== rtl/ptlt_queue.sv =====
module ptlt_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  ptlt_pkg::cmd_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output ptlt_pkg::cmd_type pop_data
);

   localparam int PW = (ptlt_pkg::QUEUE_DEPTH > 1) ? $clog2(ptlt_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(ptlt_pkg::QUEUE_DEPTH + 1);

   ptlt_pkg::cmd_type entry_ff [ptlt_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic do_push, do_pop;

   assign push_ready = (count_ff != CW'(ptlt_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(ptlt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(ptlt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CW'(do_push) - CW'(do_pop);
      end
   end

endmodule

// ===== rtl/ptlt_ratio.sv =====
module ptlt_ratio (
   input  logic                    clock,
   input  logic                    reset,
   input  ptlt_pkg::ratio_req_type ratio_req,
   output ptlt_pkg::ratio_rsp_type ratio_rsp
);

   logic        busy_ff, done_ff;
   logic [3:0]  cnt_ff;
   logic [31:0] rem_ff, den_ff;
   logic [7:0]  low_ff, q_ff;
   logic [39:0] scaled;
   logic [32:0] shifted;
   logic        ge;

   // 255*num as (num << 8) - num.
   assign scaled  = {ratio_req.num, 8'd0} - {8'd0, ratio_req.num};
   assign shifted = {rem_ff, low_ff[7]};
   assign ge      = (shifted >= {1'b0, den_ff});

   assign ratio_rsp.done = done_ff;
   assign ratio_rsp.q    = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         if (ratio_req.start) begin
            if (ratio_req.den == 32'd0) begin
               q_ff    <= 8'd0;
               done_ff <= 1'b1;
            end else if (ratio_req.num >= ratio_req.den) begin
               q_ff    <= ptlt_pkg::RATIO_MAX;
               done_ff <= 1'b1;
            end else begin
               // Quotient stays below 256, so the high part is below the divisor.
               rem_ff  <= scaled[39:8];
               low_ff  <= scaled[7:0];
               den_ff  <= ratio_req.den;
               q_ff    <= 8'd0;
               cnt_ff  <= '0;
               busy_ff <= 1'b1;
               done_ff <= 1'b0;
            end
         end else if (busy_ff) begin
            rem_ff <= ge ? 32'(shifted - {1'b0, den_ff}) : shifted[31:0];
            low_ff <= {low_ff[6:0], 1'b0};
            q_ff   <= {q_ff[6:0], ge};
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'd7) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end else if (done_ff) begin
            done_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== rtl/ptlt_back.sv =====
module ptlt_back #(
   parameter int MAX_THREADS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  ptlt_pkg::cmd_type pop_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ptlt_pkg::rsp_type rsp_data
);

   localparam int IW = $clog2(MAX_THREADS);
   localparam int CW = $clog2(MAX_THREADS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD_WAIT, S_STK_WAIT, S_SCAN_RD, S_SCAN_CMP, S_CPU_WAIT,
      S_SW_RD, S_SW_CHK, S_SW_CMP, S_OUT
   } state_type;

   state_type state_ff;
   ptlt_pkg::cmd_type cmd_ff;
   logic [63:0] prev_busy_ff, prev_all_ff;
   logic [31:0] round_cycles_ff;
   logic        stats_valid_ff;
   logic [7:0]  seen_count_ff, rounds_ff;
   logic        slot_valid_ff [MAX_THREADS];
   logic [CW-1:0] i_ff, j_ff, lim_ff;
   logic        free_ff;
   logic [IW-1:0] free_idx_ff;
   logic        track_ff;
   logic [7:0]  load_ff, cpu_ff, stk_ff;
   logic        nos_ff, over_ff;
   logic        rsp_valid_ff;
   ptlt_pkg::rsp_type rsp_ff;
   ptlt_pkg::ratio_req_type ratio_req_ff;
   ptlt_pkg::ratio_rsp_type ratio_rsp;

   logic [31:0] id_mem   [MAX_THREADS];
   logic [63:0] cyc_mem  [MAX_THREADS];
   logic [31:0] seen_mem [MAX_THREADS];
   logic [31:0] rd_id_ff, rd_seen_ff;
   logic [63:0] rd_cyc_ff;

   logic [IW-1:0] idx, jdx, free_idx_now, slot_waddr;
   logic          free_now, id_we, cyc_we, seen_we, hit, last, out_free;
   logic [31:0]   mark;

   assign idx       = i_ff[IW-1:0];
   assign jdx       = j_ff[IW-1:0];
   assign hit       = slot_valid_ff[idx] && (rd_id_ff == cmd_ff.tid);
   assign last      = (i_ff == CW'(MAX_THREADS - 1));
   assign free_now  = free_ff || !slot_valid_ff[idx];
   assign free_idx_now = free_ff ? free_idx_ff : idx;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign mark = (stats_valid_ff && pop_data.ok && pop_data.tid != 32'd0) ? pop_data.tid
                                                                          : 32'd0;

   always_comb begin
      id_we      = 1'b0;
      cyc_we     = 1'b0;
      slot_waddr = idx;
      seen_we    = (state_ff == S_IDLE) && pop_valid && (pop_data.op == ptlt_pkg::OP_SAMPLE)
                   && (seen_count_ff < 8'(MAX_THREADS));
      if (state_ff == S_SCAN_CMP) begin
         if (hit) begin
            cyc_we = 1'b1;
         end else if (last && free_now) begin
            id_we      = 1'b1;
            cyc_we     = 1'b1;
            slot_waddr = free_idx_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (id_we) begin
         id_mem[slot_waddr] <= cmd_ff.tid;
      end
      if (cyc_we) begin
         cyc_mem[slot_waddr] <= cmd_ff.tcycles;
      end
      if (seen_we) begin
         seen_mem[seen_count_ff[IW-1:0]] <= mark;
      end
      rd_id_ff   <= id_mem[idx];
      rd_cyc_ff  <= cyc_mem[idx];
      rd_seen_ff <= seen_mem[jdx];
   end

   ptlt_ratio u_ratio (
      .clock     (clock),
      .reset     (reset),
      .ratio_req (ratio_req_ff),
      .ratio_rsp (ratio_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         prev_busy_ff    <= '0;
         prev_all_ff     <= '0;
         round_cycles_ff <= '0;
         stats_valid_ff  <= 1'b0;
         seen_count_ff   <= '0;
         rounds_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
         ratio_req_ff    <= '0;
         for (int k = 0; k < MAX_THREADS; k++) begin
            slot_valid_ff[k] <= 1'b0;
         end
      end else begin
         // A start pulse always moves the state to a wait state, so no new
         // start is raised in the cycle that drops it.
         if (ratio_req_ff.start) begin
            ratio_req_ff.start <= 1'b0;
         end
         if (rsp_valid_ff && rsp_ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (pop_valid) begin
                  cmd_ff  <= pop_data;
                  load_ff <= '0;
                  cpu_ff  <= '0;
                  stk_ff  <= '0;
                  nos_ff  <= 1'b0;
                  over_ff <= 1'b0;
                  case (pop_data.op)
                     ptlt_pkg::OP_ROUND_START: begin
                        seen_count_ff <= '0;
                        if (pop_data.ok) begin
                           ratio_req_ff.start <= 1'b1;
                           ratio_req_ff.num <= pop_data.busy[31:0] - prev_busy_ff[31:0];
                           ratio_req_ff.den <= pop_data.all[31:0] - prev_all_ff[31:0];
                           round_cycles_ff  <= pop_data.all[31:0] - prev_all_ff[31:0];
                           prev_busy_ff     <= pop_data.busy;
                           prev_all_ff      <= pop_data.all;
                           stats_valid_ff   <= 1'b1;
                           state_ff         <= S_LOAD_WAIT;
                        end else begin
                           stats_valid_ff <= 1'b0;
                           state_ff       <= S_OUT;
                        end
                     end
                     ptlt_pkg::OP_SAMPLE: begin
                        if (seen_count_ff != 8'd255) begin
                           seen_count_ff <= seen_count_ff + 8'd1;
                        end
                        if (seen_count_ff >= 8'(MAX_THREADS)) begin
                           over_ff  <= 1'b1;
                           state_ff <= S_OUT;
                        end else begin
                           track_ff <= (mark != 32'd0);
                           ratio_req_ff.start <= 1'b1;
                           ratio_req_ff.num   <= pop_data.used;
                           ratio_req_ff.den   <= pop_data.size;
                           state_ff           <= S_STK_WAIT;
                        end
                     end
                     default: begin
                        lim_ff   <= (seen_count_ff >= 8'(MAX_THREADS)) ? CW'(MAX_THREADS)
                                                                        : CW'(seen_count_ff);
                        i_ff     <= '0;
                        state_ff <= S_SW_RD;
                     end
                  endcase
               end
            end
            S_LOAD_WAIT: begin
               if (ratio_rsp.done) begin
                  load_ff  <= ratio_rsp.q;
                  state_ff <= S_OUT;
               end
            end
            S_STK_WAIT: begin
               if (ratio_rsp.done) begin
                  stk_ff   <= ratio_rsp.q;
                  i_ff     <= '0;
                  free_ff  <= 1'b0;
                  state_ff <= track_ff ? S_SCAN_RD : S_OUT;
               end
            end
            S_SCAN_RD: begin
               state_ff <= S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
               if (hit) begin
                  ratio_req_ff.start <= 1'b1;
                  ratio_req_ff.num   <= cmd_ff.tcycles[31:0] - rd_cyc_ff[31:0];
                  ratio_req_ff.den   <= round_cycles_ff;
                  state_ff           <= S_CPU_WAIT;
               end else if (last) begin
                  if (free_now) begin
                     slot_valid_ff[free_idx_now] <= 1'b1;
                  end else begin
                     nos_ff <= 1'b1;
                  end
                  state_ff <= S_OUT;
               end else begin
                  free_ff     <= free_now;
                  free_idx_ff <= free_idx_now;
                  i_ff        <= i_ff + 1'b1;
                  state_ff    <= S_SCAN_RD;
               end
            end
            S_CPU_WAIT: begin
               if (ratio_rsp.done) begin
                  cpu_ff   <= ratio_rsp.q;
                  state_ff <= S_OUT;
               end
            end
            S_SW_RD: begin
               j_ff <= '0;
               if (i_ff == CW'(MAX_THREADS)) begin
                  rounds_ff <= rounds_ff + 8'd1;
                  state_ff  <= S_OUT;
               end else begin
                  state_ff <= S_SW_CHK;
               end
            end
            S_SW_CHK: begin
               if (!slot_valid_ff[idx]) begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_SW_RD;
               end else if (j_ff == lim_ff) begin
                  // Not seen this round: free the slot.
                  slot_valid_ff[idx] <= 1'b0;
                  i_ff               <= i_ff + 1'b1;
                  state_ff           <= S_SW_RD;
               end else begin
                  state_ff <= S_SW_CMP;
               end
            end
            S_SW_CMP: begin
               if (rd_seen_ff == rd_id_ff) begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_SW_RD;
               end else begin
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= S_SW_CHK;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_ff.kind          <= cmd_ff.op;
                  rsp_ff.core_load     <= load_ff;
                  rsp_ff.cpu_share     <= cpu_ff;
                  rsp_ff.stk_share     <= stk_ff;
                  rsp_ff.seen_threads  <= (cmd_ff.op == ptlt_pkg::OP_ROUND_START) ? 8'd0
                                                                                   : seen_count_ff;
                  rsp_ff.round_counter <= rounds_ff;
                  rsp_ff.no_slot       <= nos_ff;
                  rsp_ff.over_limit    <= over_ff;
                  state_ff             <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/per_thread_load_tracker.sv =====
// Round start with valid stats runs an 8-step serial ratio for core load; a thread
// sample runs an 8-step serial ratio for stack, a slot-by-slot table scan (read, then
// compare) and, on a hit, 8 more steps for cpu. Round end sweeps the table by a nested
// compare of slots against seen ids through registered memory reads.
// One request in the back at a time; a two-entry queue keeps accepting while it has room.
// Reset is synchronous, active high: clears counters, slot valid bits and the queue.
module per_thread_load_tracker #(
   parameter int MAX_THREADS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ptlt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ptlt_pkg::rsp_type rsp_data
);

   // Classified request, front to queue.
   logic              push_valid, push_ready;
   ptlt_pkg::cmd_type push_data;

   // Queue to back end.
   logic              pop_valid, pop_ready;
   ptlt_pkg::cmd_type pop_data;

   // Front: resolve stack used bytes, drop the unused opcode.
   ptlt_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Hold requests while the back end works on an earlier one.
   ptlt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Back: table, sweep, ratios and the registered response.
   ptlt_back #(
      .MAX_THREADS (MAX_THREADS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/ptlt_checker.sv =====
`include "per_thread_load_tracker_macros.svh"

module ptlt_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ptlt_pkg::rsp_type rsp_data
);

   logic stalled, is_start, start_ok, is_over, over_ok;

   assign stalled  = rsp_valid && !rsp_ready;
   assign is_start = rsp_valid && (rsp_data.kind == ptlt_pkg::OP_ROUND_START);
   assign start_ok = (rsp_data.seen_threads == 8'd0) && (rsp_data.cpu_share == 8'd0)
                     && !rsp_data.no_slot && !rsp_data.over_limit;
   assign is_over  = rsp_valid && rsp_data.over_limit;
   assign over_ok  = (rsp_data.kind == ptlt_pkg::OP_SAMPLE) && (rsp_data.cpu_share == 8'd0)
                     && (rsp_data.stk_share == 8'd0) && !rsp_data.no_slot;

   `PTLT_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_valid && $stable(rsp_data))
   `PTLT_ASSERT_IMPLY(a_kind_legal, clock, reset, rsp_valid, rsp_data.kind != ptlt_pkg::OP_IGNORED)
   `PTLT_ASSERT_IMPLY(a_start_fields, clock, reset, is_start, start_ok)
   `PTLT_ASSERT_IMPLY(a_over_quiet, clock, reset, is_over, over_ok)
   `PTLT_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)

endmodule

bind per_thread_load_tracker ptlt_checker u_ptlt_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SLOTS   = 16;
   localparam int CYCLE_LIMIT = 1500000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   ptlt_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   ptlt_pkg::rsp_type rsp_data;

   per_thread_load_tracker #(.MAX_THREADS(NUM_SLOTS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // Shadow copy of the tracker's state.
   logic [63:0] last_busy;
   logic [63:0] last_all;
   logic [31:0] round_len;
   logic        round_ok;
   logic [31:0] tbl_id[NUM_SLOTS];
   logic [63:0] tbl_cycles[NUM_SLOTS];
   logic [31:0] seen_list[NUM_SLOTS];
   logic [7:0]  seen_num;
   logic [7:0]  round_num;

   ptlt_pkg::req_type pending_reqs[$];
   ptlt_pkg::rsp_type expected_rsps[$];

   int  send_idle_pct;
   int  recv_idle_pct;
   bit  hold_requests;
   int  error_count = 0;
   int  cycle_count = 0;

   // Bank of thread ids reused across rounds so that table hits happen.
   logic [31:0] id_bank[24];
   logic [63:0] bank_cycles[24];

   logic [63:0] last_all_hint;
   logic [63:0] last_busy_hint;

   // Records whether the request on the bus was taken at the last rising edge.
   logic req_accepted;

   always #10 clock = ~clock;

   function automatic logic [7:0] scale_ratio(logic [31:0] num, logic [31:0] den);
      logic [63:0] q;
      if (den == 0) return 8'd0;
      q = (64'd255 * num) / den;
      return (q > 64'd255) ? 8'd255 : q[7:0];
   endfunction

   task automatic tracker_reset_state();
      last_busy = 0;
      last_all  = 0;
      round_len = 0;
      round_ok  = 0;
      seen_num  = 0;
      round_num = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         tbl_id[i]     = 0;
         tbl_cycles[i] = 0;
         seen_list[i]  = 0;
      end
   endtask

   // Advance the shadow state by one request and queue the response it yields.
   task automatic predict_load(ptlt_pkg::req_type r);
      ptlt_pkg::rsp_type e;
      logic [31:0] used;
      logic [31:0] unused;
      logic [31:0] mark;
      logic [31:0] delta;
      int          hit;
      int          free_idx;
      int          lim;
      bit          found;
      e = '0;
      if (r.operation == ptlt_pkg::OP_IGNORED) return;
      e.kind = r.operation;
      if (r.operation == ptlt_pkg::OP_ROUND_START) begin
         seen_num = 0;
         if (r.stats_ok) begin
            used  = r.core_busy_count[31:0] - last_busy[31:0];
            delta = r.core_all_count[31:0] - last_all[31:0];
            e.core_load = scale_ratio(used, delta);
            last_busy = r.core_busy_count;
            last_all  = r.core_all_count;
            round_len = delta;
            round_ok  = 1;
         end else begin
            round_ok = 0;
         end
      end else if (r.operation == ptlt_pkg::OP_SAMPLE) begin
         if (seen_num >= NUM_SLOTS) begin
            e.over_limit = 1;
         end else begin
            unused = r.stack_ok ? r.stk_free : 32'd0;
            used   = (unused > r.stk_bytes) ? 32'd0 : r.stk_bytes - unused;
            e.stk_share = scale_ratio(used, r.stk_bytes);
            mark = 0;
            if (round_ok && r.stats_ok && r.thread_id != 0) begin
               mark = r.thread_id;
               hit = -1;
               free_idx = -1;
               for (int i = 0; i < NUM_SLOTS; i++)
                  if (hit < 0 && tbl_id[i] == r.thread_id) hit = i;
               if (hit >= 0) begin
                  delta = r.thread_cycles[31:0] - tbl_cycles[hit][31:0];
                  tbl_cycles[hit] = r.thread_cycles;
                  e.cpu_share = scale_ratio(delta, round_len);
               end else begin
                  for (int i = 0; i < NUM_SLOTS; i++)
                     if (free_idx < 0 && tbl_id[i] == 0) free_idx = i;
                  if (free_idx >= 0) begin
                     tbl_id[free_idx]     = r.thread_id;
                     tbl_cycles[free_idx] = r.thread_cycles;
                  end else begin
                     e.no_slot = 1;
                  end
               end
            end
            seen_list[seen_num[3:0]] = mark;
         end
         if (seen_num < 8'd255) seen_num++;
      end else begin
         lim = (seen_num < NUM_SLOTS) ? int'(seen_num) : NUM_SLOTS;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (tbl_id[i] != 0) begin
               found = 0;
               for (int j = 0; j < lim; j++)
                  if (seen_list[j] == tbl_id[i]) found = 1;
               if (!found) begin
                  tbl_id[i]     = 0;
                  tbl_cycles[i] = 0;
               end
            end
         end
         round_num++;
      end
      e.seen_threads  = (r.operation == ptlt_pkg::OP_ROUND_START) ? 8'd0 : seen_num;
      e.round_counter = round_num;
      expected_rsps.push_back(e);
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h, want %0h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic ptlt_pkg::req_type make_req(logic [1:0] op);
      ptlt_pkg::req_type r;
      r = '0;
      r.operation       = op;
      r.thread_id       = $urandom();
      r.core_busy_count = rand64();
      r.core_all_count  = rand64();
      r.stats_ok        = 1'($urandom_range(0, 1));
      r.thread_cycles   = rand64();
      r.stk_bytes       = $urandom();
      r.stk_free        = $urandom();
      r.stack_ok        = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // Build a well-formed round: start, a batch of samples drawn mostly from the
   // id bank with plausible counter growth, then at times an ignored request and a round end.
   task automatic push_round(int nsamples);
      ptlt_pkg::req_type r;
      logic [31:0]       span;
      int                k;
      r = make_req(ptlt_pkg::OP_ROUND_START);
      span = $urandom_range(1000, 1000000);
      r.stats_ok = ($urandom_range(0, 9) != 0);
      r.core_all_count  = last_all_hint + span;
      r.core_busy_count = last_busy_hint + $urandom_range(0, span + span / 8);
      if ($urandom_range(0, 19) == 0) r.core_all_count = last_all_hint;
      if (r.stats_ok) begin
         last_all_hint  = r.core_all_count;
         last_busy_hint = r.core_busy_count;
      end
      pending_reqs.push_back(r);
      for (int s = 0; s < nsamples; s++) begin
         r = make_req(ptlt_pkg::OP_SAMPLE);
         r.stats_ok = ($urandom_range(0, 15) != 0);
         if ($urandom_range(0, 9) != 0) begin
            k = $urandom_range(0, 23);
            bank_cycles[k] += $urandom_range(0, span / 4 + span / 16);
            r.thread_id     = id_bank[k];
            r.thread_cycles = bank_cycles[k];
         end else if ($urandom_range(0, 3) == 0) begin
            r.thread_id = 0;
         end
         if ($urandom_range(0, 3) != 0) begin
            r.stk_bytes = $urandom_range(0, 65536);
            r.stk_free  = $urandom_range(0, r.stk_bytes + 16);
         end
         pending_reqs.push_back(r);
      end
      if ($urandom_range(0, 9) == 0)
         pending_reqs.push_back(make_req(ptlt_pkg::OP_IGNORED));
      pending_reqs.push_back(make_req(ptlt_pkg::OP_ROUND_END));
   endtask

   // Wait for the queue to drain and the block to fall idle.
   task automatic drain_all();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   // Driver: present the next request on the falling edge; hold until accepted.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (req_valid && !req_accepted) begin
         // hold valid and payload
      end else if (!hold_requests && pending_reqs.size() != 0 &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
         req_data  <= pending_reqs.pop_front();
         req_valid <= 1;
      end else begin
         req_valid <= 0;
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Monitor: predict on request acceptance, check on response acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_accepted <= 0;
      end else begin
         cycle_count++;
         req_accepted <= req_valid && req_ready;
         if (req_valid && req_ready) predict_load(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected response", 64'(rsp_data), 64'd0);
            end else begin
               ptlt_pkg::rsp_type w;
               w = expected_rsps.pop_front();
               if (rsp_data.kind != w.kind)
                  report_mismatch("kind", 64'(rsp_data.kind), 64'(w.kind));
               if (rsp_data.core_load != w.core_load)
                  report_mismatch("core_load", 64'(rsp_data.core_load), 64'(w.core_load));
               if (rsp_data.cpu_share != w.cpu_share)
                  report_mismatch("cpu_share", 64'(rsp_data.cpu_share), 64'(w.cpu_share));
               if (rsp_data.stk_share != w.stk_share)
                  report_mismatch("stk_share", 64'(rsp_data.stk_share), 64'(w.stk_share));
               if (rsp_data.seen_threads != w.seen_threads)
                  report_mismatch("seen_threads", 64'(rsp_data.seen_threads),
                                  64'(w.seen_threads));
               if (rsp_data.round_counter != w.round_counter)
                  report_mismatch("round_counter", 64'(rsp_data.round_counter),
                                  64'(w.round_counter));
               if (rsp_data.no_slot != w.no_slot)
                  report_mismatch("no_slot", 64'(rsp_data.no_slot), 64'(w.no_slot));
               if (rsp_data.over_limit != w.over_limit)
                  report_mismatch("over_limit", 64'(rsp_data.over_limit), 64'(w.over_limit));
            end
         end
         if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      ptlt_pkg::req_type r;
      int n;
      int ns;
      clock         = 0;
      reset         = 1;
      hold_requests = 0;
      send_idle_pct = 32;
      recv_idle_pct = 59;
      last_all_hint  = 0;
      last_busy_hint = 0;
      tracker_reset_state();
      for (int i = 0; i < 24; i++) begin
         id_bank[i]     = (i == 23) ? 32'hFFFF_FFFF : $urandom_range(1, 32'h7FFF_FFFF);
         bank_cycles[i] = rand64();
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed part: samples before any round start, extremes, ignored op.
      r = make_req(ptlt_pkg::OP_SAMPLE);
      r.stk_bytes = 0;
      pending_reqs.push_back(r);
      r = make_req(ptlt_pkg::OP_SAMPLE);
      r.stk_bytes = 32'hFFFF_FFFF; r.stk_free = 0; r.stack_ok = 1;
      pending_reqs.push_back(r);
      r = make_req(ptlt_pkg::OP_SAMPLE);
      r.stk_bytes = 100; r.stk_free = 200; r.stack_ok = 1;
      pending_reqs.push_back(r);
      pending_reqs.push_back(make_req(ptlt_pkg::OP_IGNORED));
      // Core counters at full scale, busy ahead of all so the ratio saturates.
      r = make_req(ptlt_pkg::OP_ROUND_START);
      r.stats_ok = 1; r.core_busy_count = '1; r.core_all_count = 64'hFFFF_FFFF_0000_0010;
      pending_reqs.push_back(r);
      // Zero round length: all deltas zero.
      r = make_req(ptlt_pkg::OP_ROUND_START);
      r.stats_ok = 1; r.core_busy_count = '1; r.core_all_count = 64'hFFFF_FFFF_0000_0010;
      pending_reqs.push_back(r);
      r = make_req(ptlt_pkg::OP_SAMPLE);
      r.stats_ok = 1; r.thread_id = 32'hFFFF_FFFF; r.thread_cycles = '1;
      pending_reqs.push_back(r);
      pending_reqs.push_back(r);
      r.thread_id = 0;
      pending_reqs.push_back(r);
      r = make_req(ptlt_pkg::OP_ROUND_START);
      r.stats_ok = 0;
      pending_reqs.push_back(r);
      r = make_req(ptlt_pkg::OP_SAMPLE);
      r.stats_ok = 1;
      pending_reqs.push_back(r);
      pending_reqs.push_back(make_req(ptlt_pkg::OP_ROUND_END));
      // Fill past the table and the thread limit.
      r = make_req(ptlt_pkg::OP_ROUND_START);
      r.stats_ok = 1; r.core_all_count = 64'd0; r.core_busy_count = 64'd0;
      pending_reqs.push_back(r);
      for (int s = 0; s < 18; s++) begin
         r = make_req(ptlt_pkg::OP_SAMPLE);
         r.stats_ok = 1; r.thread_id = 32'h100 + s;
         pending_reqs.push_back(r);
      end
      pending_reqs.push_back(make_req(ptlt_pkg::OP_ROUND_END));
      drain_all();

      // Hold off until every response is in, then continue with random rounds.
      hold_requests = 1;
      drain_all();
      hold_requests = 0;

      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin send_idle_pct = 59; recv_idle_pct = 32; end
         if (phase == 2) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         n = 0;
         while (n < 400) begin
            if ($urandom_range(0, 9) == 0) begin
               pending_reqs.push_back(make_req(2'($urandom_range(0, 3))));
               n++;
            end else begin
               ns = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 22)
                                                 : $urandom_range(0, 12);
               push_round(ns);
               n += ns + 2;
            end
         end
         drain_all();
      end
      repeat (2000) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ptlt_pkg.sv
rtl/ptlt_front.sv
rtl/ptlt_queue.sv
rtl/ptlt_ratio.sv
rtl/ptlt_back.sv
rtl/per_thread_load_tracker.sv
rtl/ptlt_checker.sv
tb/sv/tb_top.sv
